// ----- hdl/kpt_pkg.sv -----
package kpt_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);

    localparam logic [2:0] ST_FOUND     = 3'd0;
    localparam logic [2:0] ST_NOT_FOUND = 3'd1;
    localparam logic [2:0] ST_WRITTEN   = 3'd2;
    localparam logic [2:0] ST_UNCHANGED = 3'd3;
    localparam logic [2:0] ST_REJECTED  = 3'd4;

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_STORE  = 1'b1;

    typedef struct packed {
        logic         opcode;
        logic [255:0] digest;
        logic [63:0]  item_size;
        logic [63:0]  item_time;
        logic [63:0]  new_position;
    } t_req;

    typedef struct packed {
        logic [255:0] digest;
        logic [63:0]  size;
        logic [63:0]  stamp;
        logic [63:0]  position;
        logic [63:0]  age;
    } t_entry;

    typedef struct packed {
        logic             cap;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic             load_out;
    } t_cmd;

    typedef struct packed {
        logic is_store;
        logic reject;
        logic same;
    } t_sts;

endpackage

// ----- hdl/kpt_req_if.sv -----
interface kpt_req_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [63:0] digest_word_0;
    logic [63:0] digest_word_1;
    logic [63:0] digest_word_2;
    logic [63:0] digest_word_3;
    logic [63:0] item_size;
    logic [63:0] item_time;
    logic [63:0] new_position;

    modport source (
        output valid, opcode, digest_word_0, digest_word_1, digest_word_2, digest_word_3,
               item_size, item_time, new_position,
        input  ready
    );
    modport sink (
        input  valid, opcode, digest_word_0, digest_word_1, digest_word_2, digest_word_3,
               item_size, item_time, new_position,
        output ready
    );
endinterface

// ----- hdl/kpt_rsp_if.sv -----
interface kpt_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [63:0] position_out;

    modport source (
        output valid, status, position_out,
        input  ready
    );
    modport sink (
        input  valid, status, position_out,
        output ready
    );
endinterface

// ----- hdl/keyed_position_table_unit.sv -----
// Keyed position table: fully associative table of TABLE_ENTRIES entries keyed
// by a 256-bit digest, each holding size, time, saved position and age stamp.
// i_req (sink): one transfer per request. opcode 0 looks up the position of the
// first valid entry matching digest, size and time; opcode 1 stores a position,
// replacing the entry with the same digest or else the oldest entry.
// o_rsp (source): exactly one transfer per request, in request order, carrying
// status (found, not found, written, unchanged, rejected) and position_out.
// Requests are handled one at a time. Each one but a rejected store reads the
// table once, one entry per cycle through the single table read port. From the
// request transfer to o_rsp.valid a store passes the states start, scan, drain,
// write and done; a lookup skips write, and a rejected store goes from start
// straight to done. i_req.ready is high only while idle, from the cycle after
// the result is loaded, so a request is taken only once the last one is loaded.
// The result sits in an output register; the next request is taken while it
// waits, and its result is held back until the previous one has transferred.
// A stalled o_rsp therefore stalls i_req after at most one request.
// Reset (synchronous, active low) clears all valid bits and the age counter;
// entry contents, stamps included, are only used while valid.
module keyed_position_table_unit
    import kpt_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    kpt_req_if.sink   i_req,
    kpt_rsp_if.source o_rsp
);

    t_req        w_req;
    t_cmd        w_cmd;
    t_sts        w_sts;
    logic [2:0]  w_status;
    logic [63:0] w_position;

    assign w_req.opcode       = i_req.opcode;
    assign w_req.digest       = {i_req.digest_word_3, i_req.digest_word_2,
                                 i_req.digest_word_1, i_req.digest_word_0};
    assign w_req.item_size    = i_req.item_size;
    assign w_req.item_time    = i_req.item_time;
    assign w_req.new_position = i_req.new_position;

    kpt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_rsp_ready (o_rsp.ready),
        .o_rsp_valid (o_rsp.valid),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    kpt_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (w_req),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .o_status   (w_status),
        .o_position (w_position)
    );

    assign o_rsp.status       = w_status;
    assign o_rsp.position_out = w_position;

endmodule

// ----- hdl/kpt_ctrl.sv -----
module kpt_ctrl
    import kpt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_ready,
    input  logic i_rsp_ready,
    output logic o_rsp_valid,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_START = 6'b000010,
        S_SCAN  = 6'b000100,
        S_DRAIN = 6'b001000,
        S_WRITE = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_addr, n_addr;
    logic             r_out_valid, n_out_valid;
    logic             w_accept;
    logic             w_load;

    assign o_req_ready = (r_state == S_IDLE);
    assign w_accept    = i_req_valid && o_req_ready;
    assign w_load      = (r_state == S_DONE) && (!r_out_valid || i_rsp_ready);
    assign o_rsp_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        n_addr  = r_addr;
        o_cmd   = '0;
        o_cmd.rd_addr = r_addr;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.cap = 1'b1;
                    n_state   = S_START;
                end
            end
            S_START: begin
                n_addr = '0;
                if (i_sts.reject) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.rd_en = 1'b1;
                n_addr      = r_addr + 1'b1;
                if (r_addr == IDX_W'(TABLE_ENTRIES - 1)) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (i_sts.is_store) begin
                    n_state = S_WRITE;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_WRITE: begin
                o_cmd.wr_en = !i_sts.same;
                n_state     = S_DONE;
            end
            S_DONE: begin
                if (w_load) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (i_rsp_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_addr      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_out_valid <= n_out_valid;
        end
    end

    a_drain_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN) |-> ($past(r_state) == S_SCAN &&
                                  $past(r_addr) == IDX_W'(TABLE_ENTRIES - 1)))
        else $error("drain entered before last entry was read");

    a_write_store_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRITE) |-> (i_sts.is_store && !i_sts.reject))
        else $error("write phase for a lookup or rejected store");

    a_rsp_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_DONE && r_state == S_IDLE))
        else $error("response raised outside completion");

endmodule

// ----- hdl/kpt_dpath.sv -----
module kpt_dpath
    import kpt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_req        i_req,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    output logic [2:0]  o_status,
    output logic [63:0] o_position
);

    t_entry             r_mem [TABLE_ENTRIES];
    logic               r_valid [TABLE_ENTRIES];
    t_entry             r_rd_data;
    logic               r_rd_valid;
    logic               r_cmp_en;
    logic [IDX_W-1:0]   r_cmp_idx;

    t_req               r_req;
    logic               r_reject;
    logic               r_found;
    logic [63:0]        r_found_pos;
    logic               r_dhit;
    logic               r_same;
    logic [IDX_W-1:0]   r_sel;
    logic [63:0]        r_min_age;
    logic [63:0]        r_age_ctr;
    logic [2:0]         r_status;
    logic [63:0]        r_position;

    logic               w_dig_eq;
    logic               w_key_eq;
    logic               w_hit;
    logic [63:0]        w_age;
    logic [2:0]         w_status;
    logic [63:0]        w_position;
    t_entry             w_wdata;

    assign w_dig_eq = r_rd_valid && (r_rd_data.digest == r_req.digest);
    assign w_key_eq = w_dig_eq && (r_rd_data.size == r_req.item_size) &&
                      (r_rd_data.stamp == r_req.item_time);
    assign w_hit    = w_key_eq && ((r_rd_data.position < r_req.item_size) ||
                                   (r_rd_data.position == 64'd0));
    assign w_age    = r_rd_valid ? r_rd_data.age : 64'd0;

    assign w_wdata.digest   = r_req.digest;
    assign w_wdata.size     = r_req.item_size;
    assign w_wdata.stamp    = r_req.item_time;
    assign w_wdata.position = r_req.new_position;
    assign w_wdata.age      = r_age_ctr + 64'd1;

    assign o_sts.is_store = (r_req.opcode == OP_STORE);
    assign o_sts.reject   = r_reject;
    assign o_sts.same     = r_same;

    always_comb begin
        w_position = 64'd0;
        if (r_req.opcode == OP_LOOKUP) begin
            w_status = r_found ? ST_FOUND : ST_NOT_FOUND;
            if (r_found) begin
                w_position = r_found_pos;
            end
        end else if (r_reject) begin
            w_status = ST_REJECTED;
        end else if (r_same) begin
            w_status = ST_UNCHANGED;
        end else begin
            w_status = ST_WRITTEN;
        end
    end

    // table storage
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[r_sel] <= w_wdata;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[i_cmd.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                r_valid[i] <= 1'b0;
            end
            r_age_ctr  <= 64'd0;
            r_cmp_en   <= 1'b0;
            r_rd_valid <= 1'b0;
        end else begin
            r_cmp_en <= i_cmd.rd_en;
            if (i_cmd.rd_en) begin
                r_rd_valid <= r_valid[i_cmd.rd_addr];
            end
            if (i_cmd.wr_en) begin
                r_valid[r_sel] <= 1'b1;
                r_age_ctr      <= r_age_ctr + 64'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_cmp_idx <= i_cmd.rd_addr;
        end
    end

    // request capture and scan bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
            r_dhit  <= 1'b0;
            r_same  <= 1'b0;
        end else if (i_cmd.cap) begin
            r_found <= 1'b0;
            r_dhit  <= 1'b0;
            r_same  <= 1'b0;
        end else if (r_cmp_en) begin
            if (r_req.opcode == OP_LOOKUP) begin
                if (!r_found && w_hit) begin
                    r_found <= 1'b1;
                end
            end else if (!r_dhit && w_dig_eq) begin
                r_dhit <= 1'b1;
                r_same <= w_key_eq && (r_rd_data.position == r_req.new_position);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_req    <= i_req;
            r_reject <= (i_req.opcode == OP_STORE) && (i_req.new_position != 64'd0) &&
                        (i_req.new_position >= i_req.item_size);
        end
        if (r_cmp_en && (r_req.opcode == OP_LOOKUP) && !r_found && w_hit) begin
            r_found_pos <= r_rd_data.position;
        end
        if (r_cmp_en && (r_req.opcode == OP_STORE) && !r_dhit) begin
            if (w_dig_eq) begin
                r_sel <= r_cmp_idx;
            end else if ((r_cmp_idx == '0) || (w_age < r_min_age)) begin
                r_sel     <= r_cmp_idx;
                r_min_age <= w_age;
            end
        end
        if (i_cmd.load_out) begin
            r_status   <= w_status;
            r_position <= w_position;
        end
    end

    assign o_status   = r_status;
    assign o_position = r_position;

    a_write_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr_en |=> r_valid[$past(r_sel)])
        else $error("written entry not marked valid");

    a_age_on_write_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.wr_en |=> $stable(r_age_ctr))
        else $error("age counter moved without a write");

    a_found_lookup_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_found && !i_cmd.cap) |-> (r_req.opcode == OP_LOOKUP))
        else $error("hit recorded for a store");

endmodule

// ----- tb/sv/keyed_position_table_unit_test.sv -----
`timescale 1ns / 100ps

module keyed_position_table_unit_test;
    import kpt_pkg::*;

    localparam int          KEY_POOL  = 24;
    localparam int          PHASE_LEN = 150;
    localparam logic [63:0] ALL1      = '1;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] position;
    } t_reply;

    typedef struct {
        t_req   req;
        bit     typed;
        t_reply reply;
    } t_row;

    typedef struct {
        logic [255:0] digest;
        logic [63:0]  size;
        logic [63:0]  stamp;
        logic [63:0]  last_pos;
    } t_key;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    kpt_req_if req_bus();
    kpt_rsp_if rsp_bus();

    keyed_position_table_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    always #6 i_clk = ~i_clk;

    // shadow copy of the table
    bit           shadow_valid    [TABLE_ENTRIES];
    logic [255:0] shadow_digest   [TABLE_ENTRIES];
    logic [63:0]  shadow_size     [TABLE_ENTRIES];
    logic [63:0]  shadow_stamp    [TABLE_ENTRIES];
    logic [63:0]  shadow_position [TABLE_ENTRIES];
    logic [63:0]  shadow_age      [TABLE_ENTRIES];
    logic [63:0]  shadow_age_count;

    t_reply expected_replies[$];
    t_row   directed_rows[$];
    t_key   key_pool[KEY_POOL];

    int request_gap_pct = 0;
    int reply_stall_pct = 0;
    int fail_count = 0;
    int requests_sent = 0;
    int replies_seen = 0;
    int status_seen[8];

    task automatic report_mismatch(input string msg);
        $display("%0t mismatch: %s", $realtime, msg);
        fail_count++;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic bit entry_matches(input int e, input t_req r);
        return shadow_valid[e] && shadow_digest[e] == r.digest &&
               shadow_size[e] == r.item_size && shadow_stamp[e] == r.item_time;
    endfunction

    function automatic t_reply predict_table_reply(input t_req r);
        t_reply res;
        int     sel;
        bit     hit;
        res.status   = ST_NOT_FOUND;
        res.position = '0;
        hit          = 1'b0;
        sel          = 0;
        if (r.opcode == OP_LOOKUP) begin
            for (int e = 0; e < TABLE_ENTRIES; e++) begin
                if (!hit && entry_matches(e, r) &&
                    (shadow_position[e] < r.item_size || shadow_position[e] == 0)) begin
                    hit          = 1'b1;
                    res.status   = ST_FOUND;
                    res.position = shadow_position[e];
                end
            end
            return res;
        end
        if (r.new_position != 0 && r.new_position >= r.item_size) begin
            res.status = ST_REJECTED;
            return res;
        end
        for (int e = 0; e < TABLE_ENTRIES; e++) begin
            if (!hit) begin
                if (shadow_valid[e] && shadow_digest[e] == r.digest) begin
                    sel = e;
                    hit = 1'b1;
                end else if (shadow_age[e] < shadow_age[sel]) begin
                    sel = e;
                end
            end
        end
        if (entry_matches(sel, r) && shadow_position[sel] == r.new_position) begin
            res.status = ST_UNCHANGED;
            return res;
        end
        shadow_valid[sel]    = 1'b1;
        shadow_digest[sel]   = r.digest;
        shadow_size[sel]     = r.item_size;
        shadow_stamp[sel]    = r.item_time;
        shadow_position[sel] = r.new_position;
        shadow_age_count     = shadow_age_count + 64'd1;
        shadow_age[sel]      = shadow_age_count;
        res.status           = ST_WRITTEN;
        return res;
    endfunction

    function automatic t_req request_of(input logic op, input logic [255:0] dig,
                                        input logic [63:0] size, input logic [63:0] stamp,
                                        input logic [63:0] pos);
        t_req r;
        r.opcode       = op;
        r.digest       = dig;
        r.item_size    = size;
        r.item_time    = stamp;
        r.new_position = pos;
        return r;
    endfunction

    task automatic add_row(input t_req r, input bit typed, input logic [2:0] st,
                           input logic [63:0] pos);
        t_row row;
        row.req            = r;
        row.typed          = typed;
        row.reply.status   = st;
        row.reply.position = pos;
        directed_rows.push_back(row);
    endtask

    task automatic send_request(input t_req r, input bit typed, input t_reply typed_reply);
        t_reply exp;
        while ($urandom_range(99) < request_gap_pct) begin
            @(negedge i_clk);
            req_bus.valid <= 1'b0;
        end
        @(negedge i_clk);
        req_bus.valid         <= 1'b1;
        req_bus.opcode        <= r.opcode;
        req_bus.digest_word_0 <= r.digest[63:0];
        req_bus.digest_word_1 <= r.digest[127:64];
        req_bus.digest_word_2 <= r.digest[191:128];
        req_bus.digest_word_3 <= r.digest[255:192];
        req_bus.item_size     <= r.item_size;
        req_bus.item_time     <= r.item_time;
        req_bus.new_position  <= r.new_position;
        do @(posedge i_clk); while (!req_bus.ready);
        exp = predict_table_reply(r);
        if (typed) begin
            if (exp != typed_reply)
                report_mismatch($sformatf("row %0d: table rule disagrees with typed reply",
                                          requests_sent));
            exp = typed_reply;
        end
        expected_replies.push_back(exp);
        requests_sent++;
    endtask

    function automatic logic [63:0] pick_size();
        case ($urandom_range(4))
            0:       return '0;
            1:       return 64'($urandom_range(1, 16));
            2:       return ALL1;
            3:       return rand64() | (64'h1 << 63);
            default: return rand64();
        endcase
    endfunction

    function automatic logic [63:0] below(input logic [63:0] size);
        return (size == 0) ? 64'd0 : rand64() % size;
    endfunction

    function automatic t_req random_request();
        t_req r;
        int   k;
        int   roll;
        k    = $urandom_range(KEY_POOL - 1);
        roll = $urandom_range(99);
        if (roll < 10) begin
            // noise
            r.opcode       = 1'($urandom_range(1));
            r.digest       = {rand64(), rand64(), rand64(), rand64()};
            r.item_size    = pick_size();
            r.item_time    = rand64();
            r.new_position = rand64();
            return r;
        end
        if (roll < 18) begin
            // make the resident copy stale
            if ($urandom_range(1)) key_pool[k].size = pick_size();
            else key_pool[k].stamp = rand64();
        end
        r.digest    = key_pool[k].digest;
        r.item_size = key_pool[k].size;
        r.item_time = key_pool[k].stamp;
        if ($urandom_range(99) < 55) begin
            r.opcode = OP_STORE;
            roll     = $urandom_range(99);
            if (roll < 15) r.new_position = '0;
            else if (roll < 30) r.new_position = key_pool[k].last_pos;
            else if (roll < 40) begin
                r.new_position = (r.item_size >= 64'hFFFF_FFFF_FFFF_FFF0) ? ALL1 :
                                 r.item_size + 64'($urandom_range(15));
                if (r.new_position == 0) r.new_position = 64'd1;
            end else r.new_position = below(r.item_size);
            key_pool[k].last_pos = r.new_position;
        end else begin
            r.opcode       = OP_LOOKUP;
            r.new_position = rand64();
            case ($urandom_range(19))
                0:       r.item_size ^= 64'h1 << $urandom_range(63);
                1:       r.item_time ^= 64'h1 << $urandom_range(63);
                2:       r.digest ^= 256'h1 << $urandom_range(255);
                default: ;
            endcase
        end
        return r;
    endfunction

    // reply side
    initial begin
        rsp_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            rsp_bus.ready <= ($urandom_range(99) >= reply_stall_pct);
            @(posedge i_clk);
            if (i_rst_n && rsp_bus.valid && rsp_bus.ready) begin
                replies_seen++;
                status_seen[rsp_bus.status]++;
                if (expected_replies.size() == 0) begin
                    report_mismatch($sformatf("unexpected reply status %0d", rsp_bus.status));
                end else begin
                    t_reply exp;
                    exp = expected_replies.pop_front();
                    if (rsp_bus.status !== exp.status)
                        report_mismatch($sformatf("reply %0d status %0d, want %0d",
                                                  replies_seen, rsp_bus.status, exp.status));
                    if (rsp_bus.position_out !== exp.position)
                        report_mismatch($sformatf("reply %0d position %h, want %h",
                                                  replies_seen, rsp_bus.position_out,
                                                  exp.position));
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("[keyed_position_table_unit] ERROR");
        $finish;
    end

    initial begin
        logic [255:0] dig_ones;
        logic [255:0] dig_seq;
        logic [255:0] dig_swap;
        t_reply       none;
        int           gap_pct   [4] = '{0, 48, 0, 20};
        int           stall_pct [4] = '{0, 0, 48, 20};

        req_bus.valid         = 1'b0;
        req_bus.opcode        = OP_LOOKUP;
        req_bus.digest_word_0 = '0;
        req_bus.digest_word_1 = '0;
        req_bus.digest_word_2 = '0;
        req_bus.digest_word_3 = '0;
        req_bus.item_size     = '0;
        req_bus.item_time     = '0;
        req_bus.new_position  = '0;

        for (int e = 0; e < TABLE_ENTRIES; e++) begin
            shadow_valid[e]    = 1'b0;
            shadow_digest[e]   = '0;
            shadow_size[e]     = '0;
            shadow_stamp[e]    = '0;
            shadow_position[e] = '0;
            shadow_age[e]      = '0;
        end
        shadow_age_count = '0;
        for (int s = 0; s < 8; s++) status_seen[s] = 0;
        for (int k = 0; k < KEY_POOL; k++) begin
            key_pool[k].digest   = {rand64(), rand64(), rand64(), rand64()};
            key_pool[k].size     = pick_size();
            key_pool[k].stamp    = rand64();
            key_pool[k].last_pos = below(key_pool[k].size);
        end
        none.status   = ST_NOT_FOUND;
        none.position = '0;

        dig_ones = '1;
        dig_seq  = {64'h3333_4444_3333_4444, 64'h2222_1111_2222_1111,
                    64'h1111_0000_1111_0000, 64'h0000_0000_0000_00F0};
        dig_swap = {dig_seq[63:0], dig_seq[191:64], dig_seq[255:192]};

        add_row(request_of(OP_LOOKUP, '0, '0, '0, ALL1), 1, ST_NOT_FOUND, '0);
        add_row(request_of(OP_STORE, '0, '0, '0, '0), 1, ST_WRITTEN, '0);
        add_row(request_of(OP_LOOKUP, '0, '0, '0, '0), 1, ST_FOUND, '0);
        add_row(request_of(OP_STORE, '0, '0, '0, '0), 1, ST_UNCHANGED, '0);
        add_row(request_of(OP_STORE, '0, '0, '0, 64'd1), 1, ST_REJECTED, '0);
        add_row(request_of(OP_STORE, dig_ones, ALL1, ALL1, ALL1), 1, ST_REJECTED, '0);
        add_row(request_of(OP_STORE, dig_ones, ALL1, ALL1, ALL1 - 1), 1, ST_WRITTEN, '0);
        add_row(request_of(OP_LOOKUP, dig_ones, ALL1, ALL1, '0), 1, ST_FOUND, ALL1 - 1);
        add_row(request_of(OP_LOOKUP, dig_ones, ALL1, ALL1 - 1, '0), 1, ST_NOT_FOUND, '0);
        // same digest, new size: overwritten in place
        add_row(request_of(OP_STORE, dig_ones, 64'd100, ALL1, 64'd99), 1, ST_WRITTEN, '0);
        add_row(request_of(OP_LOOKUP, dig_ones, ALL1, ALL1, '0), 1, ST_NOT_FOUND, '0);
        add_row(request_of(OP_LOOKUP, dig_ones, 64'd100, ALL1, '0), 1, ST_FOUND, 64'd99);
        add_row(request_of(OP_STORE, dig_ones, 64'd100, ALL1, 64'd50), 1, ST_WRITTEN, '0);
        add_row(request_of(OP_STORE, dig_seq, 64'd1000, 64'd7, 64'd999), 1, ST_WRITTEN, '0);
        add_row(request_of(OP_LOOKUP, dig_swap, 64'd1000, 64'd7, '0), 1, ST_NOT_FOUND, '0);
        add_row(request_of(OP_LOOKUP, dig_seq, 64'd1000, 64'd7, ALL1), 1, ST_FOUND, 64'd999);
        add_row(request_of(OP_STORE, dig_seq, 64'd5, 64'd7, 64'd5), 1, ST_REJECTED, '0);
        add_row(request_of(OP_STORE, dig_seq, 64'd1000, 64'd7, 64'd999), 1, ST_UNCHANGED, '0);
        add_row(request_of(OP_LOOKUP, '0, '0, '0, ALL1), 1, ST_FOUND, '0);
        add_row(request_of(OP_STORE, {4{64'hA5A5_5A5A_A5A5_5A5A}}, 64'h8000_0000_0000_0000,
                           '0, 64'h7FFF_FFFF_FFFF_FFFF), 0, '0, '0);
        add_row(request_of(OP_LOOKUP, {4{64'hA5A5_5A5A_A5A5_5A5A}}, 64'h8000_0000_0000_0000,
                           '0, '0), 0, '0, '0);
        add_row(request_of(OP_STORE, {4{64'h5A5A_A5A5_5A5A_A5A5}}, 64'd1, 64'd1, '0),
                0, '0, '0);
        add_row(request_of(OP_LOOKUP, {4{64'h5A5A_A5A5_5A5A_A5A5}}, 64'd1, 64'd1, '0),
                0, '0, '0);

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].reply);

        for (int p = 0; p < 4; p++) begin
            request_gap_pct = gap_pct[p];
            reply_stall_pct = stall_pct[p];
            repeat (PHASE_LEN) send_request(random_request(), 0, none);
        end

        @(negedge i_clk);
        req_bus.valid <= 1'b0;
        while (expected_replies.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("covered %0d requests over four pressure phases, %0d replies checked",
                 requests_sent, replies_seen);
        $display("found %0d, not found %0d, written %0d, unchanged %0d, rejected %0d",
                 status_seen[ST_FOUND], status_seen[ST_NOT_FOUND], status_seen[ST_WRITTEN],
                 status_seen[ST_UNCHANGED], status_seen[ST_REJECTED]);
        if (fail_count == 0) begin
            $display("[keyed_position_table_unit] OK");
        end else begin
            $display("[keyed_position_table_unit] ERROR");
        end
        $finish;
    end

endmodule
